// ===== design/pwle_pkg.sv =====
// shared types and constants of the piecewise linear envelope evaluator
`default_nettype none

package pwle_pkg;

    // command codes
    localparam logic [1:0] CMD_SEG_WRITE   = 2'd0;
    localparam logic [1:0] CMD_CURVE_WRITE = 2'd1;
    localparam logic [1:0] CMD_EVAL        = 2'd2;

    // segment word layout
    localparam int DUR_W = 10;
    localparam int LVL_W = 6;

    // field widths
    localparam int TIME_W  = 17;
    localparam int RAND_W  = 15;
    localparam int VALUE_W = 19;
    localparam int CNT_W   = 7;
    localparam int START_W = 8;

    // arithmetic widths
    localparam int DIFF_W  = 17;              // top - base
    localparam int SCALE_W = 18;              // floor(diff * level / 32)
    localparam int DELTA_W = 19;              // cur_s - prev_s
    localparam int PROD_W  = 30;              // delta * offset
    localparam int QUO_W   = 29;              // divide magnitude
    localparam int RPROD_W = 35;              // sum * random value
    localparam int SHIFT_R = 15;              // random scaling shift

    // input item
    typedef struct packed {
        logic        [1:0]  command;
        logic        [8:0]  address;
        logic        [15:0] segment_word;
        logic        [6:0]  curve_count;
        logic               curve_random;
        logic        [7:0]  curve_start;
        logic signed [15:0] curve_top;
        logic signed [15:0] curve_base;
        logic        [16:0] eval_time;
        logic        [14:0] random_value;
    } t_item;

    // result item
    typedef struct packed {
        logic signed [18:0] value;
        logic               beyond_end;
    } t_result;

    // curve descriptor as stored
    typedef struct packed {
        logic        [6:0]  count;
        logic               rnd;
        logic        [7:0]  start;
        logic signed [15:0] top;
        logic signed [15:0] base;
    } t_curve;

endpackage

`default_nettype wire

// ===== design/piecewise_linear_envelope.sv =====
// top level of the piecewise linear envelope evaluator
// segment and descriptor writes finish while busy stays low
// evaluate found in a segment: walk to it, then scale, multiply, divide and combine, then strobe
// evaluate past the end of a curve: strobe once the walk has passed every segment
// the walk reads one segment word a cycle, the divide retires one bit a cycle
// synchronous active-low reset clears control and random_disable, not the stores
`default_nettype none

module piecewise_linear_envelope
    import pwle_pkg::*;
#(
    parameter int SEGMENT_WORDS = 512,
    parameter int CURVES        = 64
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_item   i_item,
    output logic         o_strobe,
    output t_result      o_result,
    input  wire logic    i_cfg_we,
    input  wire logic    i_cfg_wdata
);

    localparam int AW     = $clog2(SEGMENT_WORDS);
    localparam int CW     = (CURVES > 1) ? $clog2(CURVES) : 1;
    localparam int QCNT_W = $clog2(QUO_W + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_CURVE = 10'b00_0000_0010,
        ST_WALK  = 10'b00_0000_0100,
        ST_SCALE = 10'b00_0000_1000,
        ST_MULT  = 10'b00_0001_0000,
        ST_DLOAD = 10'b00_0010_0000,
        ST_DIV   = 10'b00_0100_0000,
        ST_FRAC  = 10'b00_1000_0000,
        ST_RAND  = 10'b01_0000_0000,
        ST_FIN   = 10'b10_0000_0000
    } t_state;

    // memories
    logic [15:0] r_seg_mem [SEGMENT_WORDS];
    t_curve      r_curve_mem [CURVES];
    logic [15:0] r_seg_q;
    t_curve      r_curve_q;

    // control
    t_state r_state, n_state;
    logic   r_random_disable;
    logic   r_strobe;
    t_result r_res;

    // item context
    logic [TIME_W-1:0]        r_time;
    logic [RAND_W-1:0]        r_rv;
    logic                     r_oor;
    logic                     r_beyond;
    logic                     r_rnd;
    logic signed [15:0]       r_base;
    logic signed [DIFF_W-1:0] r_diff;

    // walk
    logic [AW-1:0]     r_ptr;
    logic [CNT_W-1:0]  r_remain;
    logic [TIME_W-1:0] r_acc;
    logic [LVL_W-1:0]  r_prev_lvl;
    logic [LVL_W-1:0]  r_cur_lvl;
    logic [DUR_W-1:0]  r_dur;
    logic [DUR_W-1:0]  r_dt;

    // arithmetic
    logic signed [SCALE_W-1:0] r_prev_s;
    logic signed [SCALE_W-1:0] r_cur_s;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_neg;
    logic [QUO_W-1:0]          r_quo;
    logic [DUR_W-1:0]          r_rem;
    logic [QCNT_W-1:0]         r_cnt;
    logic signed [VALUE_W-1:0] r_sum;
    logic signed [RPROD_W-1:0] r_rprod;

    logic accept;
    logic seg_we, curve_we, addr_oor;
    logic [AW-1:0] seg_wa, seg_ra, start_ptr, ptr_inc;
    logic [CW-1:0] curve_a;
    logic [DUR_W-1:0] word_dur;
    logic [TIME_W:0]  seg_end;
    logic signed [SCALE_W+4:0] prev_p, cur_p;
    logic signed [DELTA_W-1:0] delta;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0] prod_mag;
    logic [DUR_W:0]    trial_in;
    logic              trial_ok;
    logic [DUR_W:0]    trial_diff;
    logic signed [VALUE_W-1:0] frac;
    logic signed [VALUE_W-1:0] base_ext;
    logic signed [VALUE_W-1:0] offset;
    logic use_rand;

    // handshake and decoded writes
    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign seg_we   = accept && (i_item.command == CMD_SEG_WRITE)
                      && (32'(i_item.address) < 32'(SEGMENT_WORDS));
    assign curve_we = accept && (i_item.command == CMD_CURVE_WRITE)
                      && (32'(i_item.address) < 32'(CURVES));
    assign addr_oor = (32'(i_item.address) >= 32'(CURVES));
    assign seg_wa   = AW'(i_item.address);
    assign curve_a  = CW'(i_item.address);

    // first segment address, start wraps at most once since SEGMENT_WORDS >= 128
    assign start_ptr = (32'(r_curve_q.start) >= 32'(SEGMENT_WORDS))
                       ? AW'(32'(r_curve_q.start) - 32'(SEGMENT_WORDS))
                       : AW'(r_curve_q.start);
    assign ptr_inc   = (r_ptr == AW'(SEGMENT_WORDS - 1)) ? '0 : r_ptr + 1'b1;
    assign seg_ra    = (r_state == ST_CURVE) ? start_ptr : r_ptr;

    // segment store
    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_seg_mem[seg_wa] <= i_item.segment_word;
        end
        r_seg_q <= r_seg_mem[seg_ra];
    end

    // curve table
    always_ff @(posedge i_clk) begin
        if (curve_we) begin
            r_curve_mem[curve_a] <= t_curve'{
                count: i_item.curve_count,
                rnd:   i_item.curve_random,
                start: i_item.curve_start,
                top:   i_item.curve_top,
                base:  i_item.curve_base
            };
        end
        r_curve_q <= r_curve_mem[curve_a];
    end

    // walk compare
    assign word_dur = r_seg_q[DUR_W-1:0];
    assign seg_end  = {1'b0, r_acc} + (TIME_W+1)'(word_dur);

    // level scaling and interpolation product
    assign prev_p   = r_diff * $signed({1'b0, r_prev_lvl});
    assign cur_p    = r_diff * $signed({1'b0, r_cur_lvl});
    assign delta    = DELTA_W'(r_cur_s) - DELTA_W'(r_prev_s);
    assign prod     = delta * $signed({1'b0, r_dt});
    assign prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // restoring divide step
    assign trial_in   = {r_rem, r_quo[QUO_W-1]};
    assign trial_ok   = (trial_in >= {1'b0, r_dur});
    assign trial_diff = trial_in - {1'b0, r_dur};

    // final combine
    assign frac     = r_neg ? -VALUE_W'(r_quo) : VALUE_W'(r_quo);
    assign base_ext = VALUE_W'(r_base);
    assign use_rand = r_rnd && !r_random_disable;
    assign offset   = use_rand ? r_rprod[SHIFT_R+VALUE_W-1:SHIFT_R] : r_sum;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.command == CMD_EVAL)) begin
                    n_state = addr_oor ? ST_FIN : ST_CURVE;
                end
            end
            ST_CURVE: begin
                n_state = (r_curve_q.count == '0) ? ST_FIN : ST_WALK;
            end
            ST_WALK: begin
                if ({1'b0, r_time} < seg_end) begin
                    n_state = ST_SCALE;
                end else if (r_remain == CNT_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_SCALE: n_state = ST_MULT;
            ST_MULT:  n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == QCNT_W'(1)) begin
                    n_state = ST_FRAC;
                end
            end
            ST_FRAC:  n_state = ST_RAND;
            ST_RAND:  n_state = ST_FIN;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_strobe         <= 1'b0;
            r_random_disable <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_FIN);
            if (i_cfg_we) begin
                r_random_disable <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_time   <= i_item.eval_time;
                r_rv     <= i_item.random_value;
                r_oor    <= addr_oor;
                r_beyond <= addr_oor;
            end
            ST_CURVE: begin
                r_rnd      <= r_curve_q.rnd;
                r_base     <= r_curve_q.base;
                r_diff     <= DIFF_W'(r_curve_q.top) - DIFF_W'(r_curve_q.base);
                r_ptr      <= (start_ptr == AW'(SEGMENT_WORDS - 1)) ? '0
                              : start_ptr + 1'b1;
                r_remain   <= r_curve_q.count;
                r_acc      <= '0;
                r_prev_lvl <= '0;
                r_beyond   <= (r_curve_q.count == '0);
            end
            ST_WALK: begin
                r_ptr     <= ptr_inc;
                r_cur_lvl <= r_seg_q[15:DUR_W];
                r_dur     <= word_dur;
                r_dt      <= DUR_W'(r_time - r_acc);
                if ({1'b0, r_time} >= seg_end) begin
                    r_acc      <= TIME_W'(seg_end);
                    r_prev_lvl <= r_seg_q[15:DUR_W];
                    r_remain   <= r_remain - 1'b1;
                    r_beyond   <= (r_remain == CNT_W'(1));
                end
            end
            ST_SCALE: begin
                r_prev_s <= prev_p[SCALE_W+4:5];
                r_cur_s  <= cur_p[SCALE_W+4:5];
            end
            ST_MULT: begin
                r_prod <= prod;
            end
            ST_DLOAD: begin
                r_neg <= r_prod[PROD_W-1];
                r_quo <= QUO_W'(prod_mag);
                r_rem <= '0;
                r_cnt <= QCNT_W'(QUO_W);
            end
            ST_DIV: begin
                r_rem <= trial_ok ? DUR_W'(trial_diff) : DUR_W'(trial_in);
                r_quo <= {r_quo[QUO_W-2:0], trial_ok};
                r_cnt <= r_cnt - 1'b1;
            end
            ST_FRAC: begin
                r_sum <= VALUE_W'(r_prev_s) + frac;
            end
            ST_RAND: begin
                r_rprod <= r_sum * $signed({1'b0, r_rv});
            end
            ST_FIN: begin
                r_res.beyond_end <= r_beyond;
                if (r_oor) begin
                    r_res.value <= '0;
                end else if (r_beyond) begin
                    r_res.value <= base_ext;
                end else begin
                    r_res.value <= base_ext + offset;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== design/pwle_checker.sv =====
// port-level checks of the envelope evaluator and their binding
`default_nettype none

module pwle_checker
    import pwle_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  start,
    input wire logic  busy,
    input wire t_item i_item,
    input wire logic  o_strobe
);

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // the result strobe is never high in consecutive cycles
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // writes and unused commands finish at once with no result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command != CMD_EVAL)) |=> (!busy && !o_strobe))
        else $error("non-evaluate item made the block busy or gave a result");

    // an evaluate item always occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command == CMD_EVAL)) |=> busy)
        else $error("evaluate item accepted without going busy");

endmodule

bind piecewise_linear_envelope pwle_checker u_pwle_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the piecewise linear envelope evaluator: random and directed items, scoreboard
module testbench;
    import pwle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_WORDS    = 512;
    localparam int NUM_CURVES   = 64;
    localparam int SEG_AW       = $clog2(SEG_WORDS);
    localparam int CURVE_AW     = $clog2(NUM_CURVES);
    localparam int TIME_MAX     = 131071;
    localparam int TAIL_CYCLES  = 170;
    localparam int SETTLE_LIMIT = 20000;
    localparam int PHASE_ITEMS  = 270;
    localparam int MAX_LINES    = 60;

    // command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // tracks the envelope store and curve table, predicts evaluated values
    class envelope_tracker;
        logic [15:0]  seg_store [SEG_WORDS];
        t_curve       curves [NUM_CURVES];
        bit           rand_off;
        t_result      pending_values [$];
        int           errors;
        int           n_evals;
        int           n_beyond;
        int           n_seg_writes;
        int           n_curve_writes;

        function new();
            foreach (seg_store[k]) seg_store[k] = '0;
            foreach (curves[k]) curves[k] = '0;
            rand_off = 1'b0;
            errors = 0;
            n_evals = 0;
            n_beyond = 0;
            n_seg_writes = 0;
            n_curve_writes = 0;
        endfunction

        function int pending();
            return pending_values.size();
        endfunction

        // update the stores or work out the value of one evaluate item
        function void note_item(t_item it);
            t_curve       c;
            t_result      r;
            logic [15:0]  w;
            longint       t, rv, acc, prev_lvl, seg_dur, seg_lvl;
            longint       top_v, base_v, diff, prev_s, cur_s, frac, res;
            int           left, idx;
            case (it.command)
                CMD_SEG_WRITE: begin
                    seg_store[it.address] = it.segment_word;
                    n_seg_writes++;
                end
                CMD_CURVE_WRITE: begin
                    if (it.address < NUM_CURVES) begin
                        c.count = it.curve_count;
                        c.rnd   = it.curve_random;
                        c.start = it.curve_start;
                        c.top   = it.curve_top;
                        c.base  = it.curve_base;
                        curves[CURVE_AW'(it.address)] = c;
                    end
                    n_curve_writes++;
                end
                CMD_EVAL: begin
                    n_evals++;
                    if (it.address >= NUM_CURVES) begin
                        r.value = '0;
                        r.beyond_end = 1'b1;
                    end else begin
                        c = curves[CURVE_AW'(it.address)];
                        t = it.eval_time;
                        rv = it.random_value;
                        acc = 0;
                        prev_lvl = 0;
                        left = c.count;
                        idx = c.start;
                        w = '0;
                        // walk segments until the time lands inside one
                        while (left != 0) begin
                            w = seg_store[SEG_AW'(idx % SEG_WORDS)];
                            seg_dur = w[DUR_W-1:0];
                            if (t < acc + seg_dur) break;
                            acc += seg_dur;
                            prev_lvl = w[DUR_W+LVL_W-1:DUR_W];
                            idx++;
                            left--;
                        end
                        top_v = c.top;
                        base_v = c.base;
                        if (left == 0) begin
                            r.value = base_v[VALUE_W-1:0];
                            r.beyond_end = 1'b1;
                        end else begin
                            seg_dur = w[DUR_W-1:0];
                            seg_lvl = w[DUR_W+LVL_W-1:DUR_W];
                            diff = top_v - base_v;
                            prev_s = (diff * prev_lvl) >>> 5;
                            cur_s = (diff * seg_lvl) >>> 5;
                            frac = ((cur_s - prev_s) * (t - acc)) / seg_dur;
                            if (c.rnd && !rand_off)
                                res = base_v + (((prev_s + frac) * rv) >>> SHIFT_R);
                            else
                                res = base_v + prev_s + frac;
                            r.value = res[VALUE_W-1:0];
                            r.beyond_end = 1'b0;
                        end
                    end
                    if (r.beyond_end) n_beyond++;
                    pending_values.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_LINES) $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // compare one strobed result with the oldest predicted value
        task check_result(t_result got);
            t_result exp_r;
            if (pending_values.size() == 0) begin
                report($sformatf("result value %0d with no evaluate pending", got.value));
            end else begin
                exp_r = pending_values.pop_front();
                if (got.value !== exp_r.value)
                    report($sformatf("value %0d, predicted %0d", got.value, exp_r.value));
                if (got.beyond_end !== exp_r.beyond_end)
                    report($sformatf("beyond_end %0b, predicted %0b",
                                     got.beyond_end, exp_r.beyond_end));
            end
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_item    i_item;
    logic     o_strobe;
    t_result  o_result;
    logic     i_cfg_we;
    logic     i_cfg_wdata;

    envelope_tracker sb;
    int idle_pct;

    piecewise_linear_envelope dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // accepted items and results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) sb.check_result(o_result);
            if (start === 1'b1 && busy === 1'b0) sb.note_item(i_item);
        end
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(t_item it);
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_for(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // drop start, wait for every predicted value, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_random_disable(bit v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.rand_off = v;
    endtask

    function automatic t_item seg_item(int addr, logic [15:0] w);
        t_item it;
        it = '0;
        it.command = CMD_SEG_WRITE;
        it.address = 9'(addr);
        it.segment_word = w;
        return it;
    endfunction

    function automatic t_item curve_item(int addr, int cnt, bit rnd, int first,
                                         int top, int base);
        t_item it;
        it = '0;
        it.command = CMD_CURVE_WRITE;
        it.address = 9'(addr);
        it.curve_count = CNT_W'(cnt);
        it.curve_random = rnd;
        it.curve_start = START_W'(first);
        it.curve_top = 16'(top);
        it.curve_base = 16'(base);
        return it;
    endfunction

    function automatic t_item eval_item(int addr, int t, int rv);
        t_item it;
        it = '0;
        it.command = CMD_EVAL;
        it.address = 9'(addr);
        it.eval_time = TIME_W'(t);
        it.random_value = RAND_W'(rv);
        return it;
    endfunction

    // segment word with durations biased toward zero, short and full length
    function automatic logic [15:0] rand_seg_word();
        logic [15:0] w;
        int          pick;
        w = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) w[DUR_W-1:0] = '0;
        else if (pick == 1) w[DUR_W-1:0] = 10'h3FF;
        else if (pick < 8) w[DUR_W-1:0] = DUR_W'($urandom_range(1, 40));
        return w;
    endfunction

    function automatic int rand_count();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return 0;
        if (pick == 2) return 127;
        return $urandom_range(1, 12);
    endfunction

    function automatic int rand_level16();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return -32768;
        if (pick == 1) return 32767;
        return $urandom_range(0, 65535) - 32768;
    endfunction

    // random item: mostly evaluations aimed inside the curve, plus writes and noise
    function automatic t_item rand_item();
        t_item        it;
        t_curve       c;
        logic [127:0] noise;
        int           pick, span, t;
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.command = CMD_SEG_WRITE;
            it.segment_word = rand_seg_word();
        end else if (pick < 45) begin
            it.command = CMD_CURVE_WRITE;
            it.address = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(NUM_CURVES, 511)
                                                        : $urandom_range(0, NUM_CURVES - 1));
            it.curve_count = CNT_W'(rand_count());
            it.curve_top = 16'(rand_level16());
            it.curve_base = 16'(rand_level16());
        end else if (pick < 95) begin
            it.command = CMD_EVAL;
            it.address = 9'(($urandom_range(0, 12) == 0) ? $urandom_range(NUM_CURVES, 511)
                                                         : $urandom_range(0, NUM_CURVES - 1));
            span = 0;
            if (it.address < NUM_CURVES) begin
                c = sb.curves[CURVE_AW'(it.address)];
                for (int k = 0; k < c.count; k++)
                    span += sb.seg_store[SEG_AW'((c.start + k) % SEG_WORDS)][DUR_W-1:0];
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) t = $urandom_range(0, span + span / 8 + 1);
            else if (pick < 80) t = (span == 0) ? 0 : span - 1;
            else if (pick < 85) t = span;
            else t = $urandom_range(0, TIME_MAX);
            if (t > TIME_MAX) t = TIME_MAX;
            it.eval_time = TIME_W'(t);
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // sender idles in about idle_pct of the cycles in which it could offer an item
    task automatic random_phase(int n);
        repeat (n) begin
            while ($urandom_range(0, 99) < idle_pct) idle_for(1);
            send_item(rand_item());
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        idle_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_random_disable(1'b0);

        // fill every segment word and every curve so no read hits an unwritten entry
        for (int a = 0; a < SEG_WORDS; a++) send_item(seg_item(a, rand_seg_word()));
        for (int a = 0; a < NUM_CURVES; a++)
            send_item(curve_item(a, rand_count(), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 255), rand_level16(), rand_level16()));

        // directed: zero duration skip, extreme levels and durations, edge curves
        send_item(seg_item(250, {6'd5, 10'd0}));
        send_item(seg_item(251, {6'd63, 10'd1}));
        send_item(seg_item(252, {6'd0, 10'd1023}));
        send_item(seg_item(253, {6'd32, 10'd10}));
        send_item(seg_item(254, 16'hFFFF));
        send_item(seg_item(511, 16'hFFFF));
        send_item(curve_item(1, 5, 1'b1, 250, 32767, -32768));
        send_item(curve_item(2, 2, 1'b0, 252, 100, 100));
        send_item(curve_item(0, 0, 1'b1, 0, 5, -7));
        send_item(curve_item(63, 127, 1'b0, 255, -32768, 32767));
        send_item(curve_item(100, 3, 1'b0, 10, 1, 2));
        send_item(eval_item(1, 0, 32767));
        send_item(eval_item(1, 1, 0));
        send_item(eval_item(1, 500, 12345));
        send_item(eval_item(1, 1033, 32767));
        send_item(eval_item(1, 2057, 1));
        send_item(eval_item(2, 5, 0));
        send_item(eval_item(0, 0, 0));
        send_item(eval_item(63, 0, 0));
        send_item(eval_item(63, TIME_MAX, 32767));
        send_item(eval_item(64, 0, 0));
        send_item(eval_item(511, TIME_MAX, 32767));
        send_item(eval_item(100, 0, 0));
        send_item('{command: CMD_UNUSED, default: '0});
        settle();

        // random phases with different sender pacing and random mode settings
        write_random_disable(1'b1);
        idle_pct = 22;
        random_phase(PHASE_ITEMS);
        settle();

        write_random_disable(1'b0);
        idle_pct = 54;
        random_phase(PHASE_ITEMS);
        settle();

        write_random_disable(1'b1);
        idle_pct = 0;
        random_phase(PHASE_ITEMS);
        settle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted values never arrived", sb.pending()));

        $display("covered %0d evaluations (%0d past the end), %0d segment and %0d curve writes",
                 sb.n_evals, sb.n_beyond, sb.n_seg_writes, sb.n_curve_writes);
        $display("random scaling enabled and disabled, sender pacing at 22, 54 and 0 percent idle");
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // overall run limit
    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== piecewise_linear_envelope.f =====
design/pwle_pkg.sv
design/piecewise_linear_envelope.sv
design/pwle_checker.sv
tb/testbench.sv
